### sv/spatial_chunk_binning_table_core_defines.svh
// Assertion macros shared by the spatial chunk binning table RTL.
`ifndef SPATIAL_CHUNK_BINNING_TABLE_CORE_DEFINES_SVH
`define SPATIAL_CHUNK_BINNING_TABLE_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SCBT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("scbt assertion failed");

// Property checked at every clock edge, also during reset.
`define SCBT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("scbt assertion failed");

`endif

### sv/scbt_pkg.sv
// Shared types, codes and helpers of the spatial chunk binning table.
package scbt_pkg;

    localparam int MAX_CHUNKS  = 256;
    localparam int MAX_OBJECTS = 1024;
    localparam int SLOT_W      = $clog2(MAX_CHUNKS);
    localparam int TOTAL_W     = $clog2(MAX_CHUNKS + 1);
    localparam int ID_W        = $clog2(MAX_OBJECTS);

    // Commands.
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_QUERY    = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_NEW_CHUNK = 3'd0;
    localparam logic [2:0] ST_MERGED    = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;
    localparam logic [2:0] ST_REG_YES   = 3'd5;
    localparam logic [2:0] ST_REG_NO    = 3'd6;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_SEEN_RD,
        S_DISPATCH,
        S_DIV,
        S_KEY_RD,
        S_KEY_CMP,
        S_BOX_RD,
        S_BOX_WR
    } seq_state_t;

    // Saturate a 33-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/scbt_div.sv
// Serial floor divider that turns one position into a biased 16-bit chunk coordinate.
module scbt_div
    import scbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic [30:0]        divisor,
    output logic               done,
    output logic [15:0]        coord
);

    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [30:0] div_reg, div_next;
    logic [30:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] coord_reg, coord_next;
    logic        done_reg, done_next;

    logic [31:0]        trial;
    logic signed [33:0] sval;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        coord_reg <= coord_next;
    end

    // One restoring step per cycle, then a floor and saturation step.
    always_comb begin
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        coord_next = coord_reg;
        trial      = {rem_reg, quo_reg[31]};
        sval       = neg_reg ? (-$signed({2'b00, quo_reg}) - $signed({33'd0, |rem_reg}))
                             : $signed({2'b00, quo_reg});
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            neg_next  = dividend[31];
            div_next  = (divisor == 31'd0) ? 31'd1 : divisor;
            rem_next  = 31'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = 31'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[30:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            if (sval > 34'sd32767) begin
                coord_next = 16'hFFFF;
            end else if (sval < -34'sd32768) begin
                coord_next = 16'h0000;
            end else begin
                coord_next = sval[15:0] ^ 16'h8000;
            end
            done_next = 1'b1;
        end
    end

    assign done  = done_reg;
    assign coord = coord_reg;

endmodule

### sv/spatial_chunk_binning_table_core.sv
// Spatial chunk binning table: top level with sequencer, tables and result register.
// A register transaction runs three serial divisions by the chunk size, one per axis, to
// set the base, then a key search that reads the held chunks one slot at a time from
// the key memory, alternating a key read and a key compare. After reset and after a
// clear the id map is swept one entry a cycle over all 1024 entries, during which no
// input transaction is taken. The result is held in an output register; the next input
// is taken once that result has been delivered.
`include "spatial_chunk_binning_table_core_defines.svh"

module spatial_chunk_binning_table_core
    import scbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [9:0]         s_object_id,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_sphere_cx,
    input  logic signed [31:0] s_sphere_cy,
    input  logic signed [31:0] s_sphere_cz,
    input  logic [30:0]        s_sphere_radius,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_chunk_slot,
    output logic [8:0]         m_chunk_total,
    output logic signed [31:0] m_box_min_x,
    output logic signed [31:0] m_box_min_y,
    output logic signed [31:0] m_box_min_z,
    output logic signed [31:0] m_box_max_x,
    output logic signed [31:0] m_box_max_y,
    output logic signed [31:0] m_box_max_z
);

    seq_state_t state_reg, state_next;

    logic [30:0] chunk_size_reg;
    logic [TOTAL_W-1:0] used_reg, used_next;
    logic [ID_W-1:0] sweep_reg, sweep_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [1:0] axis_reg, axis_next;
    logic [47:0] key_reg, key_next;

    // Captured input transaction.
    logic [1:0]         cmd_reg;
    logic [ID_W-1:0]    id_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] ctr_reg [3];
    logic [30:0]        rad_reg;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  slot_reg, slot_next;
    logic [8:0]  total_reg, total_next;
    logic signed [31:0] bmin_reg [3];
    logic signed [31:0] bmax_reg [3];
    logic signed [31:0] bmin_next [3];
    logic signed [31:0] bmax_next [3];

    // Memories.
    logic        seen_mem [MAX_OBJECTS];
    logic        seen_q;
    logic        seen_we;
    logic [ID_W-1:0] seen_waddr;
    logic        seen_wdata;
    logic [47:0] key_mem [MAX_CHUNKS];
    logic [47:0] key_q;
    logic        key_we;
    logic [191:0] box_mem [MAX_CHUNKS];
    logic [191:0] box_q;
    logic         box_we;
    logic [191:0] box_wdata;

    // Divider hookup.
    logic               div_start_reg, div_start_next;
    logic signed [31:0] div_dividend;
    logic               div_done;
    logic [15:0]        div_coord;

    logic signed [31:0] smin [3];
    logic signed [31:0] smax [3];
    logic signed [31:0] gmin [3];
    logic signed [31:0] gmax [3];

    scbt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (chunk_size_reg),
        .done     (div_done),
        .coord    (div_coord)
    );

    assign div_dividend = pos_reg[axis_reg];

    // Sphere box and merged box per axis.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            smin[a] = sat32(33'(ctr_reg[a]) - $signed({2'b00, rad_reg}));
            smax[a] = sat32(33'(ctr_reg[a]) + $signed({2'b00, rad_reg}));
            gmin[a] = (smin[a] < $signed(box_q[a*32 +: 32])) ? smin[a]
                                                              : $signed(box_q[a*32 +: 32]);
            gmax[a] = (smax[a] > $signed(box_q[96 + a*32 +: 32])) ? smax[a]
                                                                   : $signed(box_q[96 + a*32 +: 32]);
        end
    end

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= 31'd65536;
        end else if (cfg_valid) begin
            chunk_size_reg <= cfg_data;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            used_reg      <= '0;
            sweep_reg     <= '0;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            sweep_reg     <= sweep_next;
            m_valid_reg   <= m_valid_next;
            div_start_reg <= div_start_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid && s_ready) begin
            cmd_reg    <= s_command;
            id_reg     <= s_object_id;
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            ctr_reg[0] <= s_sphere_cx;
            ctr_reg[1] <= s_sphere_cy;
            ctr_reg[2] <= s_sphere_cz;
            rad_reg    <= s_sphere_radius;
        end
        idx_reg    <= idx_next;
        axis_reg   <= axis_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        total_reg  <= total_next;
        for (int a = 0; a < 3; a++) begin
            bmin_reg[a] <= bmin_next[a];
            bmax_reg[a] <= bmax_next[a];
        end
    end

    // Id map, key and box memories with registered reads.
    always_ff @(posedge aclk) begin
        if (seen_we) begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        seen_q <= seen_mem[id_reg];
        if (key_we) begin
            key_mem[used_reg[SLOT_W-1:0]] <= key_reg;
        end
        key_q <= key_mem[idx_reg];
        if (box_we) begin
            box_mem[slot_reg] <= box_wdata;
        end
        box_q <= box_mem[slot_reg];
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        sweep_next     = sweep_reg;
        idx_next       = idx_reg;
        axis_next      = axis_reg;
        key_next       = key_reg;
        div_start_next = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        total_next     = total_reg;
        for (int a = 0; a < 3; a++) begin
            bmin_next[a] = bmin_reg[a];
            bmax_next[a] = bmax_reg[a];
        end
        seen_we    = 1'b0;
        seen_waddr = id_reg;
        seen_wdata = 1'b1;
        key_we     = 1'b0;
        box_we     = 1'b0;
        box_wdata  = {smax[2], smax[1], smax[0], smin[2], smin[1], smin[0]};
        s_ready    = (state_reg == S_IDLE) && !m_valid_reg;

        case (state_reg)
            S_SWEEP: begin
                seen_we    = 1'b1;
                seen_waddr = sweep_reg;
                seen_wdata = 1'b0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == ID_W'(MAX_OBJECTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = S_SEEN_RD;
                end
            end
            S_SEEN_RD: begin
                state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                slot_next = '0;
                for (int a = 0; a < 3; a++) begin
                    bmin_next[a] = '0;
                    bmax_next[a] = '0;
                end
                total_next = used_reg;
                if (cmd_reg == CMD_CLEAR) begin
                    used_next    = '0;
                    total_next   = '0;
                    sweep_next   = '0;
                    status_next  = ST_CLEARED;
                    m_valid_next = 1'b1;
                    state_next   = S_SWEEP;
                end else if (cmd_reg == CMD_REGISTER) begin
                    if (seen_q) begin
                        status_next  = ST_DUPLICATE;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        axis_next      = 2'd0;
                        div_start_next = 1'b1;
                        state_next     = S_DIV;
                    end
                end else begin
                    status_next  = seen_q ? ST_REG_YES : ST_REG_NO;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    key_next[axis_reg*16 +: 16] = div_coord;
                    if (axis_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = S_KEY_CMP;
                        if (used_reg != '0) begin
                            state_next = S_KEY_RD;
                        end
                    end else begin
                        axis_next      = axis_reg + 2'd1;
                        div_start_next = 1'b1;
                    end
                end
            end
            S_KEY_RD: begin
                state_next = S_KEY_CMP;
            end
            S_KEY_CMP: begin
                if (used_reg != '0 && key_q == key_reg) begin
                    slot_next  = idx_reg;
                    state_next = S_BOX_RD;
                end else if (used_reg != '0 && (TOTAL_W'(idx_reg) + 1'b1) < used_reg) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_KEY_RD;
                end else if (used_reg == TOTAL_W'(MAX_CHUNKS)) begin
                    status_next  = ST_FULL;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    // New chunk goes into the next free slot.
                    slot_next    = used_reg[SLOT_W-1:0];
                    key_we       = 1'b1;
                    seen_we      = 1'b1;
                    used_next    = used_reg + 1'b1;
                    total_next   = used_reg + 1'b1;
                    status_next  = ST_NEW_CHUNK;
                    for (int a = 0; a < 3; a++) begin
                        bmin_next[a] = smin[a];
                        bmax_next[a] = smax[a];
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_BOX_WR;
                end
            end
            S_BOX_RD: begin
                state_next = S_BOX_WR;
            end
            S_BOX_WR: begin
                box_we = 1'b1;
                if (status_reg != ST_NEW_CHUNK || !m_valid_reg) begin
                    // Existing chunk: grow its box.
                    box_wdata    = {gmax[2], gmax[1], gmax[0], gmin[2], gmin[1], gmin[0]};
                    seen_we      = 1'b1;
                    status_next  = ST_MERGED;
                    for (int a = 0; a < 3; a++) begin
                        bmin_next[a] = gmin[a];
                        bmax_next[a] = gmax[a];
                    end
                    m_valid_next = 1'b1;
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_chunk_slot  = slot_reg;
    assign m_chunk_total = total_reg;
    assign m_box_min_x   = bmin_reg[0];
    assign m_box_min_y   = bmin_reg[1];
    assign m_box_min_z   = bmin_reg[2];
    assign m_box_max_x   = bmax_reg[0];
    assign m_box_max_y   = bmax_reg[1];
    assign m_box_max_z   = bmax_reg[2];

    // The table never holds more chunks than it has slots.
    `SCBT_ASSERT_ALWAYS(a_used_bound, aclk, !aresetn || used_reg <= TOTAL_W'(MAX_CHUNKS))
    // Input is only taken when idle with no result pending.
    `SCBT_ASSERT(a_ready_idle, aclk, aresetn, s_ready |-> (state_reg == S_IDLE && !m_valid_reg))
    // A division finishes only while the sequencer waits for it.
    `SCBT_ASSERT(a_div_done, aclk, aresetn, div_done |-> state_reg == S_DIV)
    // The key search never points past the chunks held.
    `SCBT_ASSERT(a_idx_bound, aclk, aresetn,
                 state_reg == S_KEY_RD |-> TOTAL_W'(idx_reg) < used_reg)

endmodule
